[hdl/prf_pkg.sv]
// Shared types and constants for the packet ring FIFO.
`default_nettype none

package prf_pkg;

    // Width of byte counts and packet lengths (up to 64 bytes).
    localparam int LEN_W = 7;

    typedef enum logic [1:0] {
        OP_APPEND     = 2'd0,
        OP_RD_BYTES   = 2'd1,
        OP_RD_SAMPLES = 2'd2,
        OP_CLEAR      = 2'd3
    } t_op;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_TOO_LONG = 3'd3;
    localparam logic [2:0] ST_INACTIVE = 3'd4;
    localparam logic [2:0] ST_ZERO_LEN = 3'd5;

    // Controller -> datapath commands.
    typedef struct packed {
        logic append;     // handle one append transfer
        logic clear;      // empty the ring, answer ok
        logic empty_rsp;  // read of an empty ring
        logic pop;        // pop oldest slot, fetch its length
        logic short_rsp;  // zero-length packet or no whole sample
        logic load;       // load byte and result counts
        logic issue;      // issue one slot byte read
    } t_cmd;

    // Datapath -> controller status.
    typedef struct packed {
        logic ring_empty;
        logic len_zero;
        logic no_sample;
        logic issue_last;
    } t_stat;

endpackage

`default_nettype wire

[hdl/packet_ring_fifo_top.sv]
// Top level of the packet ring FIFO: controller, datapath, port glue.
`default_nettype none

// Packet FIFO over a ring of SLOT_COUNT slots of SLOT_SIZE bytes; one slot
// always stays empty, so at most SLOT_COUNT-1 packets are queued.
// Command channel: a transfer happens on a clock edge with start high and
// busy low. Append transfers carry at most one byte each (byte_present, last); the
// packet commits on last, or is rejected as too long, inactive or full.
// Reads pop the oldest packet as bytes or as little-endian signed samples.
// Results: each appears for one cycle with o_valid high; the receiver
// cannot stall, so every strobed result is taken as it comes.
// Results are registered and show in the cycle after the producing edge.
// Appends and clears keep busy low: one transfer per cycle, result in the
// cycle after the transfer. A read of an empty ring also keeps busy low.
// A read of a queued packet: the length-table lookup, then one slot-RAM
// read per byte (the single read port of the byte RAM sets this), then
// a drain state; each byte passes the registered RAM read and the result
// register on its way out. A sample comes for every two bytes read.
// A zero-length or one-byte-sample packet holds busy for the lookup only.
// Config: a one-bit active register on its own valid/ready channel; ready
// is high while no read is in progress. Any write empties the ring.
// Reset: synchronous, active low; ring empty, inactive, no result pending.
// Slot storage holds no reset value and is read only after it is written.

module packet_ring_fifo_top #(
    parameter int SLOT_COUNT = 16,
    parameter int SLOT_SIZE  = 64
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // command channel
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                i_operation,
    input  wire logic [7:0]                i_data_byte,
    input  wire logic                      i_byte_present,
    input  wire logic                      i_last,
    // configuration channel
    input  wire logic                      i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire logic                      i_cfg_data,
    // results
    output logic                           o_valid,
    output logic [2:0]                     o_status,
    output logic [7:0]                     o_byte_out,
    output logic signed [15:0]             o_sample_out,
    output logic [prf_pkg::LEN_W-1:0]      o_packet_length,
    output logic                           o_end_of_run,
    output logic                           o_data_available
);
    import prf_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    t_op   op;
    logic  cfg_we;

    assign op          = t_op'(i_operation);
    assign o_cfg_ready = !busy;
    assign cfg_we      = i_cfg_valid && !busy;

    prf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    prf_datapath #(
        .SLOT_COUNT (SLOT_COUNT),
        .SLOT_SIZE  (SLOT_SIZE)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_op             (op),
        .i_data_byte      (i_data_byte),
        .i_byte_present   (i_byte_present),
        .i_last           (i_last),
        .i_cfg_we         (cfg_we),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_byte_out       (o_byte_out),
        .o_sample_out     (o_sample_out),
        .o_packet_length  (o_packet_length),
        .o_end_of_run     (o_end_of_run),
        .o_data_available (o_data_available)
    );

endmodule

`default_nettype wire

[hdl/prf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module prf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/prf_ctrl.sv]
// Sequencer for the packet ring FIFO: decodes transfers, steps reads.
`default_nettype none

module prf_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire prf_pkg::t_op   i_op,
    input  wire prf_pkg::t_stat i_stat,
    output prf_pkg::t_cmd       o_cmd,
    output logic                o_busy
);
    import prf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_STREAM,
        S_DRAIN
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_op) inside
                        OP_APPEND: o_cmd.append = 1'b1;
                        OP_CLEAR:  o_cmd.clear  = 1'b1;
                        OP_RD_BYTES, OP_RD_SAMPLES: begin
                            if (i_stat.ring_empty) begin
                                o_cmd.empty_rsp = 1'b1;
                            end else begin
                                o_cmd.pop = 1'b1;
                                n_state   = S_LEN;
                            end
                        end
                    endcase
                end
            end
            S_LEN: begin
                if (i_stat.len_zero || i_stat.no_sample) begin
                    o_cmd.short_rsp = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    o_cmd.load = 1'b1;
                    n_state    = S_STREAM;
                end
            end
            S_STREAM: begin
                o_cmd.issue = 1'b1;
                if (i_stat.issue_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

[hdl/prf_datapath.sv]
// Ring pointers, slot storage and result formatting for the packet ring FIFO.
`default_nettype none

module prf_datapath #(
    parameter int SLOT_COUNT = 16,
    parameter int SLOT_SIZE  = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire prf_pkg::t_cmd                   i_cmd,
    output prf_pkg::t_stat                       o_stat,
    input  wire prf_pkg::t_op                    i_op,
    input  wire logic [7:0]                      i_data_byte,
    input  wire logic                            i_byte_present,
    input  wire logic                            i_last,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_data,
    output logic                                 o_valid,
    output logic [2:0]                           o_status,
    output logic [7:0]                           o_byte_out,
    output logic signed [15:0]                   o_sample_out,
    output logic [prf_pkg::LEN_W-1:0]            o_packet_length,
    output logic                                 o_end_of_run,
    output logic                                 o_data_available
);
    import prf_pkg::*;

    localparam int SLOT_W    = $clog2(SLOT_COUNT);
    localparam int OFF_W     = $clog2(SLOT_SIZE);
    localparam int BYTE_AW   = SLOT_W + OFF_W;
    localparam int BYTE_DEPTH = SLOT_COUNT * (2 ** OFF_W);

    // control state
    logic              r_active, n_active;
    logic [SLOT_W-1:0] r_wr_slot, n_wr_slot;
    logic [SLOT_W-1:0] r_rd_slot, n_rd_slot;
    logic [LEN_W-1:0]  r_fill, n_fill;
    logic              r_perr, n_perr;
    logic              r_rv, n_rv;
    logic              r_o_valid, n_o_valid;

    // read-side working registers
    logic [SLOT_W-1:0] r_pop_slot, n_pop_slot;
    logic              r_view, n_view;     // 1: sample view
    logic [LEN_W-1:0]  r_total, n_total;   // bytes to fetch
    logic [LEN_W-1:0]  r_n, n_n;           // results reported as length
    logic [LEN_W-1:0]  r_cnt, n_cnt;
    logic              r_rlast, n_rlast;
    logic              r_rodd, n_rodd;
    logic [7:0]        r_lo, n_lo;

    // result register
    logic [2:0]        r_o_status, n_o_status;
    logic [7:0]        r_o_byte, n_o_byte;
    logic [15:0]       r_o_sample, n_o_sample;
    logic [LEN_W-1:0]  r_o_len, n_o_len;
    logic              r_o_eor, n_o_eor;
    logic              r_o_avail, n_o_avail;

    // RAM ports
    logic               bram_we, bram_re;
    logic [BYTE_AW-1:0] bram_waddr, bram_raddr;
    logic [7:0]         bram_rdata;
    logic               lram_we, lram_re;
    logic [LEN_W-1:0]   lram_wdata, lram_rdata;

    logic [LEN_W-1:0]  fill_v;
    logic              perr_v;
    logic [2:0]        app_status;
    logic              full;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == SLOT_W'(SLOT_COUNT - 1)) ? '0 : s + 1'b1;
    endfunction

    assign full = (next_slot(r_wr_slot) == r_rd_slot);

    assign o_stat.ring_empty = (r_wr_slot == r_rd_slot);
    assign o_stat.len_zero   = (lram_rdata == '0);
    assign o_stat.no_sample  = r_view && (lram_rdata == LEN_W'(1));
    assign o_stat.issue_last = (r_cnt == r_total - 1'b1);

    assign bram_waddr = {r_wr_slot, r_fill[OFF_W-1:0]};
    assign bram_raddr = {r_pop_slot, r_cnt[OFF_W-1:0]};

    always_comb begin
        n_active   = r_active;
        n_wr_slot  = r_wr_slot;
        n_rd_slot  = r_rd_slot;
        n_fill     = r_fill;
        n_perr     = r_perr;
        n_pop_slot = r_pop_slot;
        n_view     = r_view;
        n_total    = r_total;
        n_n        = r_n;
        n_cnt      = r_cnt;
        n_rlast    = r_rlast;
        n_rodd     = r_rodd;
        n_lo       = r_lo;
        n_rv       = 1'b0;
        n_o_valid  = 1'b0;
        n_o_status = r_o_status;
        n_o_byte   = r_o_byte;
        n_o_sample = r_o_sample;
        n_o_len    = r_o_len;
        n_o_eor    = r_o_eor;
        bram_we    = 1'b0;
        bram_re    = 1'b0;
        lram_we    = 1'b0;
        lram_re    = 1'b0;
        lram_wdata = r_fill;
        fill_v     = r_fill;
        perr_v     = r_perr;
        app_status = ST_OK;

        if (i_cfg_we) begin
            n_active  = i_cfg_data;
            n_wr_slot = '0;
            n_rd_slot = '0;
            n_fill    = '0;
            n_perr    = 1'b0;
        end

        if (i_cmd.clear) begin
            n_wr_slot  = '0;
            n_rd_slot  = '0;
            n_fill     = '0;
            n_perr     = 1'b0;
            n_o_valid  = 1'b1;
            n_o_status = ST_OK;
            n_o_byte   = '0;
            n_o_sample = '0;
            n_o_len    = '0;
            n_o_eor    = 1'b1;
        end

        if (i_cmd.append) begin
            if (i_byte_present) begin
                if (r_fill < LEN_W'(SLOT_SIZE)) begin
                    bram_we = 1'b1;
                    fill_v  = r_fill + 1'b1;
                end else begin
                    perr_v = 1'b1;
                end
            end
            n_fill = fill_v;
            n_perr = perr_v;
            if (i_last) begin
                if (perr_v) begin
                    app_status = ST_TOO_LONG;
                end else if (!r_active) begin
                    app_status = ST_INACTIVE;
                end else if (full) begin
                    app_status = ST_FULL;
                end else begin
                    lram_we    = 1'b1;
                    lram_wdata = fill_v;
                    n_wr_slot  = next_slot(r_wr_slot);
                end
                n_fill = '0;
                n_perr = 1'b0;
            end
            n_o_valid  = 1'b1;
            n_o_status = app_status;
            n_o_byte   = '0;
            n_o_sample = '0;
            n_o_len    = fill_v;
            n_o_eor    = 1'b1;
        end

        if (i_cmd.empty_rsp) begin
            n_o_valid  = 1'b1;
            n_o_status = ST_EMPTY;
            n_o_byte   = '0;
            n_o_sample = '0;
            n_o_len    = '0;
            n_o_eor    = 1'b1;
        end

        if (i_cmd.pop) begin
            lram_re    = 1'b1;
            n_pop_slot = r_rd_slot;
            n_rd_slot  = next_slot(r_rd_slot);
            n_view     = (i_op == OP_RD_SAMPLES);
        end

        if (i_cmd.short_rsp) begin
            n_o_valid  = 1'b1;
            n_o_status = o_stat.len_zero ? ST_ZERO_LEN : ST_OK;
            n_o_byte   = '0;
            n_o_sample = '0;
            n_o_len    = '0;
            n_o_eor    = 1'b1;
        end

        if (i_cmd.load) begin
            n_total = r_view ? {lram_rdata[LEN_W-1:1], 1'b0} : lram_rdata;
            n_n     = r_view ? {1'b0, lram_rdata[LEN_W-1:1]} : lram_rdata;
            n_cnt   = '0;
        end

        if (i_cmd.issue) begin
            bram_re = 1'b1;
            n_cnt   = r_cnt + 1'b1;
            n_rv    = 1'b1;
            n_rlast = o_stat.issue_last;
            n_rodd  = r_cnt[0];
        end

        // byte fetched last cycle
        if (r_rv) begin
            if (!r_view) begin
                n_o_valid  = 1'b1;
                n_o_status = ST_OK;
                n_o_byte   = bram_rdata;
                n_o_sample = '0;
                n_o_len    = r_n;
                n_o_eor    = r_rlast;
            end else if (!r_rodd) begin
                n_lo = bram_rdata;
            end else begin
                n_o_valid  = 1'b1;
                n_o_status = ST_OK;
                n_o_byte   = '0;
                n_o_sample = {bram_rdata, r_lo};
                n_o_len    = r_n;
                n_o_eor    = r_rlast;
            end
        end

        // availability after this transfer's pointer updates
        n_o_avail = (n_wr_slot != n_rd_slot);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_wr_slot <= '0;
            r_rd_slot <= '0;
            r_fill    <= '0;
            r_perr    <= 1'b0;
            r_rv      <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_active  <= n_active;
            r_wr_slot <= n_wr_slot;
            r_rd_slot <= n_rd_slot;
            r_fill    <= n_fill;
            r_perr    <= n_perr;
            r_rv      <= n_rv;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop_slot <= n_pop_slot;
        r_view     <= n_view;
        r_total    <= n_total;
        r_n        <= n_n;
        r_cnt      <= n_cnt;
        r_rlast    <= n_rlast;
        r_rodd     <= n_rodd;
        r_lo       <= n_lo;
        r_o_status <= n_o_status;
        r_o_byte   <= n_o_byte;
        r_o_sample <= n_o_sample;
        r_o_len    <= n_o_len;
        r_o_eor    <= n_o_eor;
        r_o_avail  <= n_o_avail;
    end

    prf_ram #(
        .WIDTH (8),
        .DEPTH (BYTE_DEPTH)
    ) u_byte_ram (
        .i_clk   (i_clk),
        .i_we    (bram_we),
        .i_waddr (bram_waddr),
        .i_wdata (i_data_byte),
        .i_re    (bram_re),
        .i_raddr (bram_raddr),
        .o_rdata (bram_rdata)
    );

    prf_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SLOT_COUNT)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (lram_we),
        .i_waddr (r_wr_slot),
        .i_wdata (lram_wdata),
        .i_re    (lram_re),
        .i_raddr (r_rd_slot),
        .o_rdata (lram_rdata)
    );

    assign o_valid          = r_o_valid;
    assign o_status         = r_o_status;
    assign o_byte_out       = r_o_byte;
    assign o_sample_out     = signed'(r_o_sample);
    assign o_packet_length  = r_o_len;
    assign o_end_of_run     = r_o_eor;
    assign o_data_available = r_o_avail;

endmodule

`default_nettype wire

[hdl/prf_checker.sv]
// Port-level checks for the packet ring FIFO, bound to the top level.
`default_nettype none

module prf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] i_operation,
    input wire logic       o_cfg_ready,
    input wire logic       o_valid,
    input wire logic [2:0] o_status,
    input wire logic       o_end_of_run,
    input wire logic       o_data_available
);
    import prf_pkg::*;

    // config is taken exactly when no read is in progress
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready == !busy)
        else $error("cfg ready disagrees with busy");

    // append and clear answer with a single final result next cycle
    a_short_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_operation == OP_APPEND || i_operation == OP_CLEAR)
        |=> o_valid && o_end_of_run && !busy)
        else $error("append/clear result missing");

    // clear leaves the ring empty
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_operation == OP_CLEAR
        |=> o_status == ST_OK && !o_data_available)
        else $error("clear did not empty the ring");

    // an empty-ring answer never claims data
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> !o_data_available && o_end_of_run)
        else $error("empty status with data available");

endmodule

bind packet_ring_fifo_top prf_checker u_prf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_operation      (i_operation),
    .o_cfg_ready      (o_cfg_ready),
    .o_valid          (o_valid),
    .o_status         (o_status),
    .o_end_of_run     (o_end_of_run),
    .o_data_available (o_data_available)
);

`default_nettype wire

[sim/tb_packet_ring_fifo_top.sv]
// Self-checking testbench for packet_ring_fifo_top: directed and random command traffic.
`default_nettype none

module tb_packet_ring_fifo_top;
    timeunit 1ns;
    timeprecision 1ps;

    import prf_pkg::*;

    localparam int SLOT_COUNT = 16;
    localparam int SLOT_SIZE  = 64;

    // One command transfer as the block sees it.
    typedef struct {
        t_op        op;
        logic [7:0] data;
        logic       present;
        logic       last;
    } t_ring_cmd;

    // One result as the block should strobe it.
    typedef struct {
        logic [2:0]        status;
        logic [7:0]        byte_val;
        logic signed [15:0] sample;
        logic [LEN_W-1:0]  len;
        logic              eor;
        logic              avail;
    } t_fifo_out;

    // ------------------------------------------------------------------
    // DUT ports; every input holds a known value from time zero
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_operation = OP_APPEND;
    logic [7:0] i_data_byte = 8'h00;
    logic i_byte_present = 1'b0;
    logic i_last = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic i_cfg_data = 1'b0;
    logic o_valid;
    logic [2:0] o_status;
    logic [7:0] o_byte_out;
    logic signed [15:0] o_sample_out;
    logic [LEN_W-1:0] o_packet_length;
    logic o_end_of_run;
    logic o_data_available;

    packet_ring_fifo_top #(
        .SLOT_COUNT(SLOT_COUNT),
        .SLOT_SIZE (SLOT_SIZE)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_data_byte     (i_data_byte),
        .i_byte_present  (i_byte_present),
        .i_last          (i_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_byte_out      (o_byte_out),
        .o_sample_out    (o_sample_out),
        .o_packet_length (o_packet_length),
        .o_end_of_run    (o_end_of_run),
        .o_data_available(o_data_available)
    );

    // 2 ns clock
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #1_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // Ring model: own copy of slot storage, pointers and the active bit
    // ------------------------------------------------------------------
    logic [7:0]       slot_mem [0:SLOT_COUNT*SLOT_SIZE-1];
    logic [LEN_W-1:0] slot_len [0:SLOT_COUNT-1];
    int unsigned      wr_slot  = 0;
    int unsigned      rd_slot  = 0;
    int unsigned      fill_cnt = 0;
    bit               overflow = 1'b0;  // packet being built lost a byte
    bit               active_q = 1'b0;

    t_fifo_out ring_outputs[$];  // results the block owes, oldest first
    t_ring_cmd cmd_backlog[$];   // commands not yet handed to the driver
    int        cmds_queued    = 0;
    int        mismatch_count = 0;
    int        results_seen   = 0;

    function automatic int unsigned ring_next(input int unsigned s);
        return (s + 1 >= SLOT_COUNT) ? 0 : s + 1;
    endfunction

    task automatic ring_empty_all();
        wr_slot  = 0;
        rd_slot  = 0;
        fill_cnt = 0;
        overflow = 1'b0;
    endtask

    // data_available reflects ring state after the command took effect
    task automatic ring_emit(input logic [2:0] st, input logic [7:0] b,
                             input logic signed [15:0] s, input int unsigned n,
                             input logic eor);
        t_fifo_out r;
        r.status   = st;
        r.byte_val = b;
        r.sample   = s;
        r.len      = LEN_W'(n);
        r.eor      = eor;
        r.avail    = (wr_slot != rd_slot);
        ring_outputs.push_back(r);
    endtask

    // Apply one accepted command to the model and queue what it must produce.
    task automatic ring_apply_cmd(input t_ring_cmd c);
        int unsigned base;
        int unsigned cnt;
        int unsigned n;
        int unsigned gathered;
        logic [2:0]  st;
        case (c.op)
            OP_CLEAR: begin
                ring_empty_all();
                ring_emit(ST_OK, 8'h00, 16'sd0, 0, 1'b1);
            end
            OP_APPEND: begin
                st = ST_OK;
                if (c.present) begin
                    // a byte past the slot end is dropped and poisons the packet
                    if (fill_cnt < SLOT_SIZE) begin
                        slot_mem[wr_slot*SLOT_SIZE + fill_cnt] = c.data;
                        fill_cnt++;
                    end else begin
                        overflow = 1'b1;
                    end
                end
                gathered = fill_cnt;
                if (c.last) begin
                    if (overflow) begin
                        st = ST_TOO_LONG;
                    end else if (!active_q) begin
                        st = ST_INACTIVE;
                    end else if (ring_next(wr_slot) == rd_slot) begin
                        st = ST_FULL;  // one slot always stays empty
                    end else begin
                        slot_len[wr_slot] = LEN_W'(fill_cnt);
                        wr_slot = ring_next(wr_slot);
                    end
                    fill_cnt = 0;
                    overflow = 1'b0;
                end
                ring_emit(st, 8'h00, 16'sd0, gathered, 1'b1);
            end
            default: begin
                if (wr_slot == rd_slot) begin
                    ring_emit(ST_EMPTY, 8'h00, 16'sd0, 0, 1'b1);
                end else begin
                    base = rd_slot * SLOT_SIZE;
                    cnt  = slot_len[rd_slot];
                    rd_slot = ring_next(rd_slot);
                    if (cnt == 0) begin
                        ring_emit(ST_ZERO_LEN, 8'h00, 16'sd0, 0, 1'b1);
                    end else if (c.op == OP_RD_BYTES) begin
                        for (int i = 0; i < cnt; i++)
                            ring_emit(ST_OK, slot_mem[base+i], 16'sd0, cnt, i == cnt - 1);
                    end else begin
                        // little-endian pairs; an odd tail byte is dropped
                        n = cnt / 2;
                        if (n == 0) begin
                            ring_emit(ST_OK, 8'h00, 16'sd0, 0, 1'b1);
                        end else begin
                            for (int i = 0; i < n; i++)
                                ring_emit(ST_OK, 8'h00,
                                          {slot_mem[base+2*i+1], slot_mem[base+2*i]},
                                          n, i == n - 1);
                        end
                    end
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("[%0t] ERROR result %0d: %s", $time, results_seen, msg);
    endtask

    // ------------------------------------------------------------------
    // Driver: bursts of command transfers with random gaps in between.
    // item_held is updated with blocking writes so the stimulus process
    // sees backlog and held state change together.
    // ------------------------------------------------------------------
    t_ring_cmd held_cmd   = '{OP_APPEND, 8'h00, 1'b0, 1'b0};
    bit        item_held  = 1'b0;
    int        burst_left = 0;
    int        gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            // transfer completes on start high with busy low
            if (item_held && start && !busy) begin
                ring_apply_cmd(held_cmd);
                item_held = 1'b0;
            end
            if (!item_held) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (cmd_backlog.size() != 0) begin
                    held_cmd  = cmd_backlog.pop_front();
                    item_held = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 9))
                            0, 1, 2, 3: gap_left = 0;
                            9:          gap_left = $urandom_range(5, 12);
                            default:    gap_left = $urandom_range(1, 4);
                        endcase
                    end else begin
                        burst_left--;
                    end
                end
            end
            start          <= item_held;
            i_operation    <= held_cmd.op;
            i_data_byte    <= held_cmd.data;
            i_byte_present <= held_cmd.present;
            i_last         <= held_cmd.last;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobed result is taken and checked against the
    // oldest owed result, field by field.
    // ------------------------------------------------------------------
    t_fifo_out head_out;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0) begin
            if (ring_outputs.size() == 0) begin
                report_mismatch("strobe with no result owed");
            end else begin
                head_out = ring_outputs.pop_front();
                if (o_valid !== 1'b1)
                    report_mismatch("strobe is unknown");
                if (o_status !== head_out.status)
                    report_mismatch($sformatf("status %0d, model %0d",
                                              o_status, head_out.status));
                if (o_byte_out !== head_out.byte_val)
                    report_mismatch($sformatf("byte 0x%02h, model 0x%02h",
                                              o_byte_out, head_out.byte_val));
                if (o_sample_out !== head_out.sample)
                    report_mismatch($sformatf("sample %0d, model %0d",
                                              o_sample_out, head_out.sample));
                if (o_packet_length !== head_out.len)
                    report_mismatch($sformatf("length %0d, model %0d",
                                              o_packet_length, head_out.len));
                if (o_end_of_run !== head_out.eor)
                    report_mismatch($sformatf("end_of_run %b, model %b",
                                              o_end_of_run, head_out.eor));
                if (o_data_available !== head_out.avail)
                    report_mismatch($sformatf("data_available %b, model %b",
                                              o_data_available, head_out.avail));
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_cmd(input t_op op, input logic [7:0] d, input logic p,
                            input logic l);
        t_ring_cmd c;
        c.op      = op;
        c.data    = d;
        c.present = p;
        c.last    = l;
        cmd_backlog.push_back(c);
        cmds_queued++;
    endtask

    // Well-formed packet of n_bytes real bytes, with the odd ignored
    // (not-present) filler; last rides on the final byte or on an empty item.
    task automatic push_packet(input int n_bytes);
        bit tail_on_byte;
        tail_on_byte = (n_bytes != 0) && $urandom_range(0, 1);
        for (int i = 0; i < n_bytes; i++) begin
            if ($urandom_range(0, 19) == 0)
                push_cmd(OP_APPEND, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_cmd(OP_APPEND, 8'($urandom_range(0, 255)), 1'b1,
                     tail_on_byte && (i == n_bytes - 1));
        end
        if (!tail_on_byte)
            push_cmd(OP_APPEND, 8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Mostly packets and reads; a little clear and fully random noise.
    task automatic push_traffic(input int n_items, input int read_pct,
                                input int len_max, input int long_pct);
        int first;
        int r;
        first = cmds_queued;
        while (cmds_queued - first < n_items) begin
            r = $urandom_range(0, 99);
            if (r < read_pct) begin
                push_cmd(t_op'($urandom_range(OP_RD_BYTES, OP_RD_SAMPLES)),
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            end else if (read_pct != 0 && r < read_pct + 3) begin
                push_cmd(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            end else if (r < read_pct + 9) begin
                push_cmd(t_op'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if ($urandom_range(0, 99) < long_pct) begin
                // around the slot size: 62..66 bytes, over 64 is too long
                push_packet($urandom_range(SLOT_SIZE - 2, SLOT_SIZE + 2));
            end else begin
                push_packet($urandom_range(0, len_max));
            end
        end
    endtask

    // Wait until every command has been taken and every result has come.
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || item_held || ring_outputs.size() != 0)
            @(posedge i_clk);
    endtask

    // Write the active bit; only called with the block idle. Any write
    // empties the ring, in the model as in the block.
    task automatic write_active(input logic v);
        repeat (4) @(posedge i_clk);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        active_q = v;
        ring_empty_all();
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Inactive after reset: reads of an empty ring, rejected appends.
        push_cmd(OP_RD_BYTES,   8'h00, 1'b0, 1'b0);
        push_cmd(OP_RD_SAMPLES, 8'hFF, 1'b1, 1'b1);
        push_cmd(OP_APPEND,     8'hA5, 1'b1, 1'b1);
        push_cmd(OP_APPEND,     8'h00, 1'b0, 1'b1);
        push_cmd(OP_CLEAR,      8'hFF, 1'b1, 1'b1);
        wait_drained();
        write_active(1'b1);

        // zero-length, two-byte, one-byte and three-byte packets
        push_cmd(OP_APPEND, 8'h3C, 1'b0, 1'b1);
        push_cmd(OP_APPEND, 8'h00, 1'b1, 1'b0);
        push_cmd(OP_APPEND, 8'hFF, 1'b1, 1'b1);
        push_cmd(OP_APPEND, 8'h80, 1'b1, 1'b1);
        push_cmd(OP_APPEND, 8'h01, 1'b1, 1'b0);
        push_cmd(OP_APPEND, 8'h5A, 1'b0, 1'b0);  // ignored filler
        push_cmd(OP_APPEND, 8'h80, 1'b1, 1'b0);
        push_cmd(OP_APPEND, 8'h7F, 1'b1, 1'b0);
        push_cmd(OP_APPEND, 8'h00, 1'b0, 1'b1);  // ends without a byte
        // zero-length pop, negative sample, no whole sample, odd tail, empty
        push_cmd(OP_RD_BYTES,   8'h00, 1'b0, 1'b0);
        push_cmd(OP_RD_SAMPLES, 8'h00, 1'b0, 1'b0);
        push_cmd(OP_RD_SAMPLES, 8'hFF, 1'b1, 1'b1);
        push_cmd(OP_RD_SAMPLES, 8'h00, 1'b1, 1'b0);
        push_cmd(OP_RD_BYTES,   8'hFF, 1'b0, 1'b1);
        // clear drops a half-built packet
        push_cmd(OP_APPEND,   8'h11, 1'b1, 1'b0);
        push_cmd(OP_CLEAR,    8'h00, 1'b0, 1'b0);
        push_cmd(OP_APPEND,   8'h22, 1'b1, 1'b1);
        push_cmd(OP_RD_BYTES, 8'h00, 1'b0, 1'b0);
        wait_drained();

        // Random phases, each behind a fresh register write.
        write_active(1'b1);
        push_traffic(30, 30, 8, 0);     // mixed
        wait_drained();
        write_active(1'b1);
        push_traffic(45, 0, 2, 0);      // fill until the ring is full
        push_traffic(30, 60, 8, 0);     // drain past empty
        wait_drained();
        write_active(1'b0);
        push_traffic(15, 30, 8, 0);     // appends rejected as inactive
        wait_drained();
        write_active(1'b1);
        push_traffic(90, 25, 8, 30);    // packets at and past slot size
        wait_drained();
        write_active(1'b1);
        push_traffic(20, 35, 8, 5);
        wait_drained();

        // let any trailing drain cycle pass, then judge
        repeat (10) @(posedge i_clk);
        if (ring_outputs.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", ring_outputs.size()));
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
